// ===== rtl/lcgx_pkg.sv =====
// Shared types and constants for the LCG keystream XOR cipher.
package lcgx_pkg;

  localparam int unsigned TermW    = 32;
  localparam int unsigned ProdW    = 2 * TermW;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned DataW    = 32;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned RegIdxW  = 2;

  // Remainder unit retires this many dividend bits per cycle.
  localparam int unsigned ModBitsPerCycle = 2;
  localparam int unsigned ModSteps        = ProdW / ModBitsPerCycle;
  localparam int unsigned ModCntW         = $clog2(ModSteps);

  localparam logic [TermW-1:0] SeedReset = 32'd0;
  localparam logic [TermW-1:0] MultReset = 32'd1103515245;
  localparam logic [TermW-1:0] IncrReset = 32'd12345;
  localparam logic [TermW-1:0] ModReset  = 32'd2147483647;

  typedef enum logic [RegIdxW-1:0] {
    REG_SEED = 2'd0,
    REG_MULT = 2'd1,
    REG_INCR = 2'd2,
    REG_MOD  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_MOD
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

endpackage

// ===== rtl/lcg_keystream_xor_cipher_top.sv =====
// Top level of the LCG keystream XOR cipher with its register port.
//
// Usage:
// - Input channel (in_valid, in_stall, data_byte, restart): one item is one byte.
//   restart high loads seed_value into the generator term before the byte is used.
// - Output channel (out_valid, out_stall, cipher_byte): cipher_byte is data_byte XOR
//   the low byte of the term in use. It is registered the cycle after accept.
// - Register port (APB style, pready always high): seed_value at 0x0, multiplier at
//   0x4, increment at 0x8, modulus at 0xC. Write only while the block is idle.
// - out_valid rises in the cycle after accept.
// - Term update: no new item is taken until the next term is ready. After accept,
//   the next term passes through the 32x32 multiply, the 64-bit add and the
//   remainder unit, which retires two dividend bits a cycle. With modulus zero the
//   remainder is skipped.
// - Reset: registers return to their defaults, the term clears to zero and the
//   output register empties.
// - Stall: a result held under out_stall keeps the input stalled; the next item
//   is taken once the result leaves and the term update has finished.
module lcg_keystream_xor_cipher_top (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lcgx_pkg::ByteW-1:0]    data_byte,
  input  logic                          restart,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lcgx_pkg::ByteW-1:0]    cipher_byte,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcgx_pkg::AddrW-1:0]    paddr,
  input  logic [lcgx_pkg::DataW-1:0]    pwdata,
  output logic [lcgx_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  // configuration registers
  logic [lcgx_pkg::TermW-1:0] seed_value;
  logic [lcgx_pkg::TermW-1:0] multiplier;
  logic [lcgx_pkg::TermW-1:0] increment;
  logic [lcgx_pkg::TermW-1:0] modulus;

  lcgx_pkg::reg_idx_t         reg_idx;
  logic                       cfg_write;

  // datapath
  lcgx_pkg::state_t           state;
  lcgx_pkg::state_t           state_next;
  logic [lcgx_pkg::TermW-1:0] term;
  logic [lcgx_pkg::TermW-1:0] term_used;
  logic [lcgx_pkg::ProdW-1:0] prod;
  logic [lcgx_pkg::ProdW-1:0] sum;
  logic                       in_fire;
  logic                       out_fire;
  logic                       mod_zero;

  // sequencer outputs
  logic                       mod_start;
  logic                       term_from_sum;
  logic                       term_from_rem;
  logic                       prod_load;

  logic [lcgx_pkg::TermW-1:0] remainder;
  lcgx_pkg::mod_status_t      mod_status;

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = lcgx_pkg::reg_idx_t'(paddr[lcgx_pkg::AddrW-1:2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= lcgx_pkg::SeedReset;
      multiplier <= lcgx_pkg::MultReset;
      increment  <= lcgx_pkg::IncrReset;
      modulus    <= lcgx_pkg::ModReset;
    end else if (cfg_write) begin
      case (reg_idx)
        lcgx_pkg::REG_SEED: seed_value <= pwdata;
        lcgx_pkg::REG_MULT: multiplier <= pwdata;
        lcgx_pkg::REG_INCR: increment  <= pwdata;
        lcgx_pkg::REG_MOD:  modulus    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lcgx_pkg::REG_SEED: prdata = seed_value;
      lcgx_pkg::REG_MULT: prdata = multiplier;
      lcgx_pkg::REG_INCR: prdata = increment;
      lcgx_pkg::REG_MOD:  prdata = modulus;
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  // Take a new item only when idle and the output register can hold its result.
  assign in_stall  = (state != lcgx_pkg::ST_IDLE) || (out_valid && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign term_used = restart ? seed_value : term;
  assign mod_zero  = (modulus == '0);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      lcgx_pkg::ST_IDLE: if (in_fire) state_next = lcgx_pkg::ST_MUL;
      lcgx_pkg::ST_MUL:  state_next = lcgx_pkg::ST_ADD;
      lcgx_pkg::ST_ADD:  state_next = mod_zero ? lcgx_pkg::ST_IDLE : lcgx_pkg::ST_MOD;
      lcgx_pkg::ST_MOD:  if (mod_status.done) state_next = lcgx_pkg::ST_IDLE;
      default:           state_next = lcgx_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: control outputs
  always_comb begin
    prod_load     = 1'b0;
    mod_start     = 1'b0;
    term_from_sum = 1'b0;
    term_from_rem = 1'b0;
    case (state)
      lcgx_pkg::ST_MUL: prod_load = 1'b1;
      lcgx_pkg::ST_ADD: begin
        // Modulus zero means 2^32: keep the low word of the sum.
        mod_start     = !mod_zero;
        term_from_sum = mod_zero;
      end
      lcgx_pkg::ST_MOD: term_from_rem = mod_status.done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcgx_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Term datapath
  // ---------------------------------------------------------------------------
  // Full-width sum never overflows 64 bits.
  assign sum = prod + lcgx_pkg::ProdW'(increment);

  always_ff @(posedge clk) begin
    if (rst) begin
      term <= '0;
    end else if (in_fire) begin
      term <= term_used;
    end else if (term_from_sum) begin
      term <= sum[lcgx_pkg::TermW-1:0];
    end else if (term_from_rem) begin
      term <= remainder;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_load) begin
      prod <= lcgx_pkg::ProdW'(multiplier) * lcgx_pkg::ProdW'(term);
    end
  end

  lcgx_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (sum),
    .divisor   (modulus),
    .remainder (remainder),
    .status    (mod_status)
  );

  // ---------------------------------------------------------------------------
  // Output register: hold the result until taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cipher_byte <= data_byte ^ term_used[lcgx_pkg::ByteW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_status.done |-> state == lcgx_pkg::ST_MOD)
    else $error("remainder done outside its wait state");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    mod_status.busy |-> in_stall)
    else $error("input open while remainder unit busy");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid && state == lcgx_pkg::ST_MUL)
    else $error("accepted item did not produce a result");

  a_zero_mod_short: assert property (@(posedge clk) disable iff (rst)
    state == lcgx_pkg::ST_ADD && mod_zero |=> state == lcgx_pkg::ST_IDLE && !mod_status.busy)
    else $error("modulus zero started the remainder unit");

endmodule

// ===== rtl/lcgx_mod.sv =====
// Iterative remainder unit: 64-bit dividend modulo a 32-bit divisor, two bits per cycle.
module lcgx_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lcgx_pkg::ProdW-1:0]    dividend,
  input  logic [lcgx_pkg::TermW-1:0]    divisor,
  output logic [lcgx_pkg::TermW-1:0]    remainder,
  output lcgx_pkg::mod_status_t         status
);

  logic [lcgx_pkg::ProdW-1:0]   dvd;
  logic [lcgx_pkg::TermW-1:0]   dsr;
  logic [lcgx_pkg::TermW-1:0]   rem;
  logic [lcgx_pkg::TermW-1:0]   rem_next;
  logic [lcgx_pkg::ModCntW-1:0] count;
  logic                         busy;
  logic                         done;

  logic [lcgx_pkg::TermW:0]     trial1;
  logic [lcgx_pkg::TermW:0]     trial2;
  logic [lcgx_pkg::TermW-1:0]   rem_mid;

  // Two restoring steps; the partial remainder stays below the divisor.
  always_comb begin
    trial1 = {rem, dvd[lcgx_pkg::ProdW-1]};
    if (trial1 >= {1'b0, dsr}) begin
      trial1 = trial1 - {1'b0, dsr};
    end
    rem_mid = trial1[lcgx_pkg::TermW-1:0];
    trial2  = {rem_mid, dvd[lcgx_pkg::ProdW-2]};
    if (trial2 >= {1'b0, dsr}) begin
      trial2 = trial2 - {1'b0, dsr};
    end
    rem_next = trial2[lcgx_pkg::TermW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + lcgx_pkg::ModCntW'(1);
        if (count == lcgx_pkg::ModCntW'(lcgx_pkg::ModSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[lcgx_pkg::ProdW-3:0], 2'b00};
      rem <= rem_next;
    end
  end

  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the LCG keystream XOR cipher top level.
module tb_top;

  // Run limit in clock cycles. The run issues 2017 items, plus stalls and pauses.
  localparam int unsigned CycleLimit = 800_000;
  // Term update after a result: multiply, add and remainder.
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned RandomPhases = 9;
  localparam int unsigned ItemsPerPhase = 222;

  typedef struct {
    logic [lcgx_pkg::ByteW-1:0] data;
    logic                       restart;
  } byte_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic [lcgx_pkg::ByteW-1:0] data_byte = '0;
  logic                       restart   = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [lcgx_pkg::ByteW-1:0] cipher_byte;

  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [lcgx_pkg::AddrW-1:0] paddr   = '0;
  logic [lcgx_pkg::DataW-1:0] pwdata  = '0;
  logic [lcgx_pkg::DataW-1:0] prdata;
  logic                       pready;

  // Local copy of the key registers and the generator term.
  logic [lcgx_pkg::TermW-1:0] key_seed = lcgx_pkg::SeedReset;
  logic [lcgx_pkg::TermW-1:0] key_mult = lcgx_pkg::MultReset;
  logic [lcgx_pkg::TermW-1:0] key_incr = lcgx_pkg::IncrReset;
  logic [lcgx_pkg::TermW-1:0] key_mod  = lcgx_pkg::ModReset;
  logic [lcgx_pkg::TermW-1:0] lcg_term = '0;

  byte_item_t                 pending_bytes[$];
  logic [lcgx_pkg::ByteW-1:0] expected_cipher_q[$];

  int unsigned issued_count  = 0;
  int unsigned checked_count = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  lcg_keystream_xor_cipher_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cipher_byte (cipher_byte),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #10 clk = ~clk;

  // Advance the generator one step. The product and sum are kept at 64 bits;
  // a zero modulus stands for 2^32, i.e. keep the low word.
  function automatic logic [lcgx_pkg::TermW-1:0] advance_term(
      input logic [lcgx_pkg::TermW-1:0] term);
    logic [lcgx_pkg::ProdW-1:0] full;
    full = lcgx_pkg::ProdW'(key_mult) * lcgx_pkg::ProdW'(term) +
           lcgx_pkg::ProdW'(key_incr);
    if (key_mod == '0) begin
      return full[lcgx_pkg::TermW-1:0];
    end
    return lcgx_pkg::TermW'(full % lcgx_pkg::ProdW'(key_mod));
  endfunction

  // Pick a key word biased toward the corners: zero, all ones, tiny values.
  function automatic logic [lcgx_pkg::TermW-1:0] pick_key_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return lcgx_pkg::TermW'($urandom_range(15));
      default: return lcgx_pkg::TermW'($urandom);
    endcase
  endfunction

  // Driver: hold the item under stall, take the next one only after acceptance.
  // The term is predicted at the accepting edge from the values still on the port.
  always @(posedge clk) begin
    byte_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (restart) begin
          lcg_term = key_seed;
        end
        expected_cipher_q.push_back(data_byte ^ lcg_term[lcgx_pkg::ByteW-1:0]);
        lcg_term = advance_term(lcg_term);
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_valid  <= 1'b1;
          data_byte <= nxt.data;
          restart   <= nxt.restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the output at random and check every accepted result
  // against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        if (expected_cipher_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected cipher_byte: expected none, actual 0x%02h",
                   $time, cipher_byte);
        end else begin
          if (cipher_byte !== expected_cipher_q[0]) begin
            error_count++;
            $display("%0t: cipher_byte mismatch: expected 0x%02h, actual 0x%02h",
                     $time, expected_cipher_q[0], cipher_byte);
          end
          void'(expected_cipher_q.pop_front());
          checked_count++;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_item(input logic [lcgx_pkg::ByteW-1:0] data, input logic rs);
    byte_item_t it;
    it.data    = data;
    it.restart = rs;
    pending_bytes.push_back(it);
    issued_count++;
  endtask

  // Wait until every issued item has produced its result, then let the term
  // update of the last item finish before touching the registers.
  task automatic drain_and_settle();
    while (checked_count != issued_count) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value at
  // the edge that ends the access cycle.
  task automatic write_key_reg(input lcgx_pkg::reg_idx_t idx,
                               input logic [lcgx_pkg::TermW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lcgx_pkg::AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lcgx_pkg::REG_SEED: key_seed = value;
      lcgx_pkg::REG_MULT: key_mult = value;
      lcgx_pkg::REG_INCR: key_incr = value;
      lcgx_pkg::REG_MOD:  key_mod  = value;
      default: ;
    endcase
  endtask

  task automatic write_key_set(input logic [lcgx_pkg::TermW-1:0] seed,
                               input logic [lcgx_pkg::TermW-1:0] mult,
                               input logic [lcgx_pkg::TermW-1:0] incr,
                               input logic [lcgx_pkg::TermW-1:0] md);
    write_key_reg(lcgx_pkg::REG_SEED, seed);
    write_key_reg(lcgx_pkg::REG_MULT, mult);
    write_key_reg(lcgx_pkg::REG_INCR, incr);
    write_key_reg(lcgx_pkg::REG_MOD, md);
  endtask

  initial begin
    int unsigned ph;
    int unsigned n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, mild idling so handshakes still see some gaps.
    send_idle_pct = 7;
    recv_idle_pct = 58;

    // Default keys: the term runs from zero after reset, and the restart reloads the zero seed.
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'h5A, 1'b0);
    add_item(8'hA5, 1'b1);
    add_item(8'h3C, 1'b0);
    drain_and_settle();

    // All ones everywhere: the seed equals the modulus and is used unreduced.
    write_key_set('1, '1, '1, '1);
    add_item(8'h00, 1'b1);
    add_item(8'hFF, 1'b0);
    add_item(8'h0F, 1'b0);
    add_item(8'hF0, 1'b0);
    drain_and_settle();

    // Seed far above a small modulus.
    write_key_set(32'hFFFF_FFF0, 32'd3, 32'd7, 32'h10);
    add_item(8'h00, 1'b1);
    add_item(8'h81, 1'b0);
    add_item(8'h7E, 1'b0);
    drain_and_settle();

    // Zero modulus: wrap at 2^32 instead of reducing.
    write_key_set(32'h1234_5678, '1, '1, '0);
    add_item(8'h00, 1'b1);
    add_item(8'hFF, 1'b0);
    add_item(8'h55, 1'b0);
    add_item(8'hAA, 1'b1);
    drain_and_settle();

    // Modulus one with zero multiplier and increment: every later term is zero.
    write_key_set(32'h1234_5678, '0, '0, 32'd1);
    add_item(8'hC3, 1'b1);
    add_item(8'h3C, 1'b0);
    add_item(8'hFF, 1'b0);
    drain_and_settle();

    // Random part: new keys each phase, messages of random length and content.
    for (ph = 0; ph < RandomPhases; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 7;
        recv_idle_pct = 58;
      end else if (ph < 6) begin
        send_idle_pct = 58;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_key_set(pick_key_word(), pick_key_word(), pick_key_word(), pick_key_word());
      for (n = 0; n < ItemsPerPhase; n++) begin
        // Most phases open a fresh message; some carry the old term over.
        add_item(lcgx_pkg::ByteW'($urandom),
                 (n == 0) ? ($urandom_range(3) != 0) : ($urandom_range(11) == 0));
      end
      drain_and_settle();
    end

    // Every result is in and the last term update has settled.
    if (error_count == 0 && expected_cipher_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
